### src/ccrn_pkg.sv
// Shared types, constants and the power-factor table for the response normalizer.
package ccrn_pkg;

    localparam int MAX_CHANNELS   = 64;
    localparam int POW_ITERATIONS = 16;
    localparam int ADDR_W = $clog2(MAX_CHANNELS);
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int IT_W   = $clog2(POW_ITERATIONS + 1);
    localparam int SUM_W  = 37;
    localparam int E_W    = 56;

    // Configuration register indexes
    localparam logic [7:0] REG_BIAS_K = 8'd0;
    localparam logic [7:0] REG_SCALE  = 8'd1;
    localparam logic [7:0] REG_BETA   = 8'd2;
    localparam logic [7:0] REG_WINDOW = 8'd3;

    typedef struct packed {
        logic [31:0] bias_k;
        logic [15:0] scale_factor;
        logic [15:0] beta_exponent;
        logic [6:0]  window_size;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_A, ST_SQ_B, ST_WIN, ST_ACC, ST_NORM, ST_LOG,
        ST_LGF, ST_LGI, ST_EXP, ST_MAG, ST_FIN, ST_OUT
    } state_t;

    typedef logic [31:0] factor_tab_t [POW_ITERATIONS];

    // Truncated integer square root, evaluated at elaboration only
    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        longint unsigned vv;
        res  = 0;
        bitv = 64'd1 << 62;
        vv   = v;
        for (int k = 0; k < 32; k++) begin
            if (vv >= res + bitv) begin
                vv  = vv - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Factors 2^(2^-(i+1)) for entry i, Q2.30, each the square root of the previous
    function automatic factor_tab_t build_factors();
        factor_tab_t tab;
        longint unsigned r;
        r = 64'd2 << 30;
        for (int i = 0; i < POW_ITERATIONS; i++) begin
            r = isqrt64(r << 30);
            tab[i] = r[31:0];
        end
        return tab;
    endfunction

    localparam factor_tab_t POW_FACTORS = build_factors();

endpackage

### src/ccrn_store.sv
// Sample and scaled-square memories with registered read ports.
module ccrn_store (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ccrn_pkg::ADDR_W-1:0] wr_addr,
    input  logic [15:0]               wr_sample,
    input  logic [31:0]               wr_square,
    input  logic [ccrn_pkg::ADDR_W-1:0] rd_sq_addr,
    input  logic [ccrn_pkg::ADDR_W-1:0] rd_smp_addr,
    output logic [31:0]               rd_square,
    output logic [15:0]               rd_sample
);

    logic [15:0] sample_mem [ccrn_pkg::MAX_CHANNELS];
    logic [31:0] square_mem [ccrn_pkg::MAX_CHANNELS];

    // Write one channel, read the window entry and the current sample
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_mem[wr_addr] <= wr_sample;
            square_mem[wr_addr] <= wr_square;
        end
        rd_square <= square_mem[rd_sq_addr];
        rd_sample <= sample_mem[rd_smp_addr];
    end

endmodule

### src/ccrn_engine.sv
// Sequencer with one shared multiplier: squares, window sums, log2/exp2 power, output.
module ccrn_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ccrn_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          in_sample,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_value,
    output logic                 out_sat,
    output logic                 out_last
);

    localparam int AW = ccrn_pkg::ADDR_W;
    localparam int CW = ccrn_pkg::CNT_W;
    localparam int IW = ccrn_pkg::IT_W;
    localparam int SW = ccrn_pkg::SUM_W;
    localparam int EW = ccrn_pkg::E_W;
    localparam int NI = ccrn_pkg::POW_ITERATIONS;
    localparam int FW = $clog2(NI);

    ccrn_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] c_reg, c_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [15:0]   raw_reg, raw_next;
    logic          last_reg, last_next;
    logic [31:0]   sq_reg, sq_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] sh_reg, sh_next;
    logic [5:0]    p_reg, p_next;
    logic [30:0]   m_reg, m_next;
    logic [NI-1:0] frac_reg, frac_next;
    logic [IW-1:0] it_reg, it_next;
    logic [47:0]   t_reg, t_next;
    logic [EW-1:0] e_reg, e_next;
    logic [31:0]   y_reg, y_next;
    logic [47:0]   mag_reg, mag_next;
    logic          zero_reg, zero_next;
    logic [15:0]   val_reg, val_next;
    logic          sat_reg, sat_next;
    logic          olast_reg, olast_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        wr_en;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_square;
    logic [15:0] rd_sample;

    ccrn_store u_store (
        .aclk        (aclk),
        .wr_en       (wr_en),
        .wr_addr     (count_reg[AW-1:0]),
        .wr_sample   (raw_reg),
        .wr_square   (prod[47:16]),
        .rd_sq_addr  (rd_addr),
        .rd_smp_addr (c_reg),
        .rd_square   (rd_square),
        .rd_sample   (rd_sample)
    );

    // Shared multiplier
    assign prod = 64'(mul_a) * 64'(mul_b);

    // Helpers
    logic [15:0] in_ax, cur_ax;
    logic        cur_neg;
    logic [6:0]  win_len;
    logic [5:0]  before_n, after_n;
    logic [7:0]  hi_t, n_m1;
    logic [SW-1:0] acc_sum;
    logic [31:0] frac32, log_pr;
    logic [4:0]  pdist;
    logic [EW-1:0] ipart, bl;
    logic signed [11:0] ip;
    logic signed [12:0] sft;
    logic [12:0] nsft;
    logic [63:0] shv;
    logic [15:0] limit;
    logic        hit_last_it;

    assign in_ax   = raw_reg[15] ? 16'(-raw_reg) : raw_reg;
    assign cur_neg = rd_sample[15];
    assign cur_ax  = cur_neg ? 16'(-rd_sample) : rd_sample;
    assign win_len = (cfg.window_size == 7'd0) ? 7'd1 : cfg.window_size;
    assign before_n = 6'((win_len - 7'd1) >> 1);
    assign after_n  = 6'(((win_len + 7'd1) >> 1) - 7'd1);
    assign hi_t     = 8'(c_reg) + 8'(after_n);
    assign n_m1     = 8'(count_reg) - 8'd1;
    assign acc_sum  = acc_reg + SW'(rd_square);
    assign frac32   = 32'(frac_reg) << (32 - NI);
    assign log_pr   = prod[61:30];
    assign pdist    = (p_reg >= 6'd16) ? 5'(p_reg - 6'd16) : 5'(6'd16 - p_reg);
    assign ipart    = EW'(prod[20:0]) << 32;
    assign bl       = (p_reg >= 6'd16) ? ipart + EW'(t_reg) : EW'(t_reg) - ipart;
    assign ip       = e_reg[EW-1:44];
    assign sft      = 13'sd30 - 13'(ip);
    assign nsft     = 13'(-sft);
    assign limit    = cur_neg ? 16'h8000 : 16'h7FFF;
    assign hit_last_it = (it_reg == IW'(NI - 1));

    assign in_ready  = (state_reg == ccrn_pkg::ST_IDLE);
    assign out_valid = (state_reg == ccrn_pkg::ST_OUT);
    assign out_value = val_reg;
    assign out_sat   = sat_reg;
    assign out_last  = olast_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccrn_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (count_reg < CW'(ccrn_pkg::MAX_CHANNELS)) begin
                        state_next = ccrn_pkg::ST_SQ_A;
                    end else if (in_last) begin
                        state_next = ccrn_pkg::ST_WIN;
                    end
                end
            end
            ccrn_pkg::ST_SQ_A: state_next = ccrn_pkg::ST_SQ_B;
            ccrn_pkg::ST_SQ_B: state_next = last_reg ? ccrn_pkg::ST_WIN : ccrn_pkg::ST_IDLE;
            ccrn_pkg::ST_WIN:  state_next = ccrn_pkg::ST_ACC;
            ccrn_pkg::ST_ACC: begin
                if (i_reg == hi_reg) begin
                    state_next = (acc_sum == '0) ? ccrn_pkg::ST_FIN : ccrn_pkg::ST_NORM;
                end
            end
            ccrn_pkg::ST_NORM: begin
                if (sh_reg[SW-1] || p_reg == 6'd0) state_next = ccrn_pkg::ST_LOG;
            end
            ccrn_pkg::ST_LOG:  if (hit_last_it) state_next = ccrn_pkg::ST_LGF;
            ccrn_pkg::ST_LGF:  state_next = ccrn_pkg::ST_LGI;
            ccrn_pkg::ST_LGI:  state_next = ccrn_pkg::ST_EXP;
            ccrn_pkg::ST_EXP:  if (hit_last_it) state_next = ccrn_pkg::ST_MAG;
            ccrn_pkg::ST_MAG:  state_next = ccrn_pkg::ST_FIN;
            ccrn_pkg::ST_FIN:  state_next = ccrn_pkg::ST_OUT;
            ccrn_pkg::ST_OUT: begin
                if (out_ready) begin
                    state_next = (8'(c_reg) == n_m1) ? ccrn_pkg::ST_IDLE : ccrn_pkg::ST_WIN;
                end
            end
            default: state_next = ccrn_pkg::ST_IDLE;
        endcase
    end

    // Datapath and multiplier operand selection
    always_comb begin
        count_next = count_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        hi_next    = hi_reg;
        raw_next   = raw_reg;
        last_next  = last_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        t_next     = t_reg;
        e_next     = e_reg;
        y_next     = y_reg;
        mag_next   = mag_reg;
        zero_next  = zero_reg;
        val_next   = val_reg;
        sat_next   = sat_reg;
        olast_next = olast_reg;
        mul_a      = '0;
        mul_b      = '0;
        wr_en      = 1'b0;
        rd_addr    = AW'(i_reg + AW'(1));
        shv        = '0;
        case (state_reg)
            ccrn_pkg::ST_IDLE: begin
                if (in_valid) begin
                    raw_next  = in_sample;
                    last_next = in_last;
                    c_next    = '0;
                end
            end
            ccrn_pkg::ST_SQ_A: begin
                mul_a   = 32'(in_ax);
                mul_b   = 32'(in_ax);
                sq_next = prod[31:0];
            end
            ccrn_pkg::ST_SQ_B: begin
                // Store sample and its scaled square
                mul_a      = sq_reg;
                mul_b      = 32'(cfg.scale_factor);
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
            end
            ccrn_pkg::ST_WIN: begin
                i_next   = (c_reg >= before_n) ? AW'(c_reg - AW'(before_n)) : '0;
                rd_addr  = i_next;
                hi_next  = (hi_t > n_m1) ? AW'(n_m1) : AW'(hi_t);
                acc_next = SW'(cfg.bias_k);
            end
            ccrn_pkg::ST_ACC: begin
                acc_next  = acc_sum;
                i_next    = AW'(i_reg + AW'(1));
                sh_next   = acc_sum;
                p_next    = 6'(SW - 1);
                zero_next = (acc_sum == '0);
            end
            ccrn_pkg::ST_NORM: begin
                if (sh_reg[SW-1] || p_reg == 6'd0) begin
                    m_next    = sh_reg[SW-1:SW-31];
                    it_next   = '0;
                    frac_next = '0;
                end else begin
                    sh_next = sh_reg << 1;
                    p_next  = p_reg - 6'd1;
                end
            end
            ccrn_pkg::ST_LOG: begin
                // Square the mantissa, take one fraction bit
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
                if (log_pr[31]) begin
                    m_next    = log_pr[31:1];
                    frac_next = {frac_reg[NI-2:0], 1'b1};
                end else begin
                    m_next    = log_pr[30:0];
                    frac_next = {frac_reg[NI-2:0], 1'b0};
                end
                it_next = hit_last_it ? '0 : IW'(it_reg + IW'(1));
            end
            ccrn_pkg::ST_LGF: begin
                mul_a  = 32'(cfg.beta_exponent);
                mul_b  = frac32;
                t_next = prod[47:0];
            end
            ccrn_pkg::ST_LGI: begin
                mul_a  = 32'(cfg.beta_exponent);
                mul_b  = 32'(pdist);
                e_next = EW'(-bl);
                y_next = 32'h4000_0000;
            end
            ccrn_pkg::ST_EXP: begin
                // Apply the factor for each set fraction bit
                mul_a = y_reg;
                mul_b = ccrn_pkg::POW_FACTORS[it_reg[FW-1:0]];
                if (e_reg[6'(43 - 32'(it_reg))]) y_next = prod[61:30];
                it_next = IW'(it_reg + IW'(1));
            end
            ccrn_pkg::ST_MAG: begin
                mul_a    = 32'(cur_ax);
                mul_b    = y_reg;
                mag_next = prod[47:0];
            end
            ccrn_pkg::ST_FIN: begin
                // Scale by the power of two, saturate, restore sign
                if (zero_reg) begin
                    shv = (cur_ax == 16'd0) ? 64'd0 : 64'(limit) + 64'd1;
                end else if (mag_reg == '0) begin
                    shv = '0;
                end else if (!sft[12]) begin
                    shv = (sft > 13'sd63) ? 64'd0 : (64'(mag_reg) >> sft[5:0]);
                end else begin
                    shv = (nsft >= 13'd18) ? 64'd1 << 20 : (64'(mag_reg) << nsft[4:0]);
                end
                if (shv > 64'(limit)) begin
                    val_next = cur_neg ? 16'h8000 : 16'h7FFF;
                    sat_next = 1'b1;
                end else begin
                    val_next = cur_neg ? 16'(-shv[15:0]) : shv[15:0];
                    sat_next = zero_reg;
                end
                olast_next = (8'(c_reg) == n_m1);
            end
            ccrn_pkg::ST_OUT: begin
                if (out_ready) begin
                    if (8'(c_reg) == n_m1) begin
                        count_next = '0;
                    end else begin
                        c_next = AW'(c_reg + AW'(1));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccrn_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        c_reg     <= c_next;
        i_reg     <= i_next;
        hi_reg    <= hi_next;
        raw_reg   <= raw_next;
        last_reg  <= last_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        sh_reg    <= sh_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        it_reg    <= it_next;
        t_reg     <= t_next;
        e_reg     <= e_next;
        y_reg     <= y_next;
        mag_reg   <= mag_next;
        zero_reg  <= zero_next;
        val_reg   <= val_next;
        sat_reg   <= sat_next;
        olast_reg <= olast_next;
    end

endmodule

### src/cross_channel_response_norm_top.sv
// Top level: stream ports, configuration registers and the normalization engine.
// Each input transfer is stored in the steps ST_SQ_A and ST_SQ_B (one shared multiplier, two products).
// Each result is built by window summing, normalize shifts, log2, exp2 and final scaling;
// a zero window sum skips the normalize and power steps.
// Results leave one at a time; no input is taken while a run is being emitted.
// aresetn is synchronous: it restores register defaults and empties the channel count.
module cross_channel_response_norm_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] normalized_value
    output logic        m_tuser,   // [0] saturated
    output logic        m_tlast
);

    ccrn_pkg::cfg_t cfg_reg, cfg_next;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                ccrn_pkg::REG_BIAS_K: cfg_next.bias_k        = cfg_wdata;
                ccrn_pkg::REG_SCALE:  cfg_next.scale_factor  = cfg_wdata[15:0];
                ccrn_pkg::REG_BETA:   cfg_next.beta_exponent = cfg_wdata[15:0];
                ccrn_pkg::REG_WINDOW: cfg_next.window_size   = cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias_k        <= 32'd65536;
            cfg_reg.scale_factor  <= 16'd655;
            cfg_reg.beta_exponent <= 16'd3072;
            cfg_reg.window_size   <= 7'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ccrn_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

### src/ccrn_checker.sv
// Port-level checks for the normalizer, bound to the top level.
module ccrn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Never take input while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while result offered");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast)) else $error("stalled result changed");

    // Return to input after the last result of a run
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("run did not end after last result");

    // Stay ready while no input transfer arrives
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |=> s_tready) else $error("ready dropped without transfer");

    // Nothing offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result offered after reset");

endmodule

bind cross_channel_response_norm_top ccrn_checker u_ccrn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### test/cross_channel_response_norm_checker.sv
// Checker for the response normalizer: predicts results from observed transfers and compares.
`timescale 1ns / 100ps

module cross_channel_response_norm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] normalized_value
    input  logic        m_tuser,   // [0] saturated
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] FRAC44  = (64'd1 << 44) - 1;

    typedef struct packed {
        logic [15:0] value;
        logic        sat;
        logic        last;
    } norm_result_t;

    norm_result_t expected_norm [$];

    // Shadow registers and channel stores
    logic [31:0] bias_q;
    logic [15:0] scale_q;
    logic [15:0] beta_q;
    logic [6:0]  window_q;
    logic [15:0] sample_mem [ccrn_pkg::MAX_CHANNELS];
    logic [31:0] square_mem [ccrn_pkg::MAX_CHANNELS];
    int          chan_cnt;

    assign pending = expected_norm.size();

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Magnitude |x| * S^(-beta), Q8.8, truncated, capped at 2^20
    function automatic logic [63:0] power_scaled(logic [63:0] ax, logic [63:0] sum,
                                                 logic [15:0] beta);
        int          p;
        logic [63:0] m, frac, frac32, u, ipu, f, f32, y, r, magv;
        longint      lg, e, ip, s;
        p = 63;
        while (p > 0 && sum[p] == 1'b0) p--;
        m = (p <= 30) ? (sum << (30 - p)) : (sum >> (p - 30));
        frac = 0;
        for (int i = 0; i < ccrn_pkg::POW_ITERATIONS; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 2 * ONE_Q30) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        frac32 = (ccrn_pkg::POW_ITERATIONS >= 32)
                 ? (frac >> (ccrn_pkg::POW_ITERATIONS - 32))
                 : (frac << (32 - ccrn_pkg::POW_ITERATIONS));
        lg = longint'(p - 16) * (longint'(1) <<< 32) + longint'(frac32);
        e  = -longint'({48'd0, beta}) * lg;
        if (e >= 0) begin
            ip = longint'(64'(e) >> 44);
        end else begin
            u  = 64'(-e);
            ip = -longint'((u + FRAC44) >> 44);
        end
        ipu = 64'(ip);
        f   = (64'(e) - (ipu << 44)) & FRAC44;
        f32 = f >> 12;
        y = ONE_Q30;
        r = 2 * ONE_Q30;
        for (int i = 1; i <= ccrn_pkg::POW_ITERATIONS && i <= 32; i++) begin
            r = int_sqrt(r << 30);
            if (f32[32 - i]) y = (y * r) >> 30;
        end
        magv = ax * y;
        s = 30 - ip;
        if (magv == 0) return 0;
        if (s >= 0) return (s >= 63) ? 64'd0 : (magv >> s);
        if (-s >= 18) return 64'd1 << 20;
        return magv << (-s);
    endfunction

    // Push one result per stored channel of the position
    task automatic emit_position();
        int           len, lo, hi, nb, na;
        logic [63:0]  sum, ax, lim, mag;
        logic         neg, sat;
        norm_result_t res;
        len = (window_q == 0) ? 1 : int'(window_q);
        nb  = (len - 1) / 2;
        na  = (len + 1) / 2 - 1;
        for (int c = 0; c < chan_cnt; c++) begin
            lo  = (c - nb < 0) ? 0 : c - nb;
            hi  = (c + na > chan_cnt - 1) ? chan_cnt - 1 : c + na;
            sum = {32'd0, bias_q};
            for (int i = lo; i <= hi; i++) sum = sum + {32'd0, square_mem[i]};
            neg = sample_mem[c][15];
            ax  = neg ? (64'h10000 - sample_mem[c]) : {48'd0, sample_mem[c]};
            lim = neg ? 64'd32768 : 64'd32767;
            sat = 1'b0;
            if (sum == 0) begin
                mag = (ax == 0) ? 64'd0 : lim;
                sat = 1'b1;
            end else begin
                mag = power_scaled(ax, sum, beta_q);
                if (mag > lim) begin
                    mag = lim;
                    sat = 1'b1;
                end
            end
            res.value = neg ? 16'(64'h10000 - mag) : mag[15:0];
            res.sat   = sat;
            res.last  = (c == chan_cnt - 1);
            expected_norm.push_back(res);
        end
        chan_cnt = 0;
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;

    // Track configuration, inputs and results on each rising edge
    always @(posedge aclk) begin
        norm_result_t want;
        logic [63:0]  ax;
        if (!aresetn) begin
            bias_q   <= 32'd65536;
            scale_q  <= 16'd655;
            beta_q   <= 16'd3072;
            window_q <= 7'd5;
            chan_cnt = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    ccrn_pkg::REG_BIAS_K: bias_q   <= cfg_wdata;
                    ccrn_pkg::REG_SCALE:  scale_q  <= cfg_wdata[15:0];
                    ccrn_pkg::REG_BETA:   beta_q   <= cfg_wdata[15:0];
                    ccrn_pkg::REG_WINDOW: window_q <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (chan_cnt < ccrn_pkg::MAX_CHANNELS) begin
                    ax = s_tdata[15] ? (64'h10000 - s_tdata) : {48'd0, s_tdata};
                    sample_mem[chan_cnt] = s_tdata;
                    square_mem[chan_cnt] = 32'(((ax * ax) * {48'd0, scale_q}) >> 16);
                    chan_cnt++;
                end
                if (s_tlast) emit_position();
            end
            if (m_tvalid && m_tready) begin
                if (expected_norm.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 16'h0);
                end else begin
                    want = expected_norm.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("normalized_value", m_tdata, want.value);
                    if (m_tuser !== want.sat)
                        report_mismatch("saturated", {15'd0, m_tuser}, {15'd0, want.sat});
                    if (m_tlast !== want.last)
                        report_mismatch("last_result", {15'd0, m_tlast}, {15'd0, want.last});
                end
            end
        end
    end

endmodule

### test/cross_channel_response_norm_top_tb.sv
// Testbench top for the response normalizer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cross_channel_response_norm_top_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_addr = 8'd0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          pending;
    int          idle_mode = 0;

    always #2 aclk = ~aclk;

    cross_channel_response_norm_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    cross_channel_response_norm_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .mismatches(mismatches), .pending(pending)
    );

    // Stall the result channel according to the idle phase
    always @(negedge aclk) begin
        case (idle_mode)
            2: m_tready = ($urandom_range(0, 99) >= 61);
            3: m_tready = ($urandom_range(0, 99) >= 37);
            default: m_tready = 1'b1;
        endcase
    end

    function automatic int gap_pct();
        return (idle_mode == 1) ? 61 : (idle_mode == 3) ? 37 : 0;
    endfunction

    // Present one sample and hold it until the transfer completes
    task automatic send_sample(logic [15:0] value, logic last);
        logic ready_seen;
        while ($urandom_range(0, 99) < gap_pct()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tlast  = last;
        do begin
            ready_seen = s_tready;
            @(negedge aclk);
        end while (!ready_seen);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [7:0] addr, logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Drain all results, then let the engine go quiet
    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic load_config(logic [31:0] bias, logic [15:0] scale, logic [15:0] beta,
                               logic [6:0] win);
        drain();
        write_reg(ccrn_pkg::REG_BIAS_K, bias);
        write_reg(ccrn_pkg::REG_SCALE, {16'($urandom), scale});
        write_reg(ccrn_pkg::REG_BETA, {16'($urandom), beta});
        write_reg(ccrn_pkg::REG_WINDOW, {25'($urandom), win});
        write_reg(8'd4 + 8'($urandom_range(0, 251)), $urandom);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1: return 16'($signed(16'($urandom_range(0, 64))) - 16'sd32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_position(int n);
        for (int i = 0; i < n; i++) send_sample(pick_sample(), i == n - 1);
    endtask

    initial begin
        int items;
        int n;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: field extremes and short positions under reset settings
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'h0100, 1'b0);
        send_sample(16'hff00, 1'b0);
        send_sample(16'h0001, 1'b1);
        // Zero window sum: no bias and no squares
        load_config(32'd0, 16'd0, 16'd4096, 7'd3);
        send_sample(16'h0005, 1'b0);
        send_sample(16'hfffb, 1'b0);
        send_sample(16'h0000, 1'b1);
        // Extreme beta with tiny sum forces clipping; zero window acts as one
        load_config(32'd1, 16'd1, 16'hffff, 7'd0);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);
        // Channel overflow: more samples than stores
        load_config(32'd65536, 16'd655, 16'd3072, 7'd5);
        for (int i = 0; i < 70; i++) send_sample(16'($urandom), i == 69);

        // Random phases across settings and idle modes
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: load_config(32'd65536, 16'd655, 16'd3072, 7'd5);
                1: load_config(32'd0, 16'hffff, 16'hffff, 7'd1);
                2: load_config(32'hffffffff, 16'd0, 16'd0, 7'd64);
                3: load_config(32'd0, 16'd0, 16'd4096, 7'd127);
                4: load_config(32'd256, 16'hffff, 16'd12288, 7'd2);
                default: load_config($urandom_range(0, 1) ? $urandom : $urandom_range(0, 300),
                                     16'($urandom), 16'($urandom_range(0, 16384)),
                                     7'($urandom_range(0, 64)));
            endcase
            idle_mode = ph % 4;
            items = 0;
            while (items < 25) begin
                case ($urandom_range(0, 19))
                    0: n = $urandom_range(9, 64);
                    1: n = (ph == 5) ? $urandom_range(65, 70) : $urandom_range(1, 3);
                    default: n = $urandom_range(1, 8);
                endcase
                send_position(n);
                items += n;
            end
        end

        idle_mode = 0;
        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("cross_channel_response_norm_top_tb OK");
        end else begin
            $display("cross_channel_response_norm_top_tb NOT OK");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(4 * 20000000);
        $display("cross_channel_response_norm_top_tb NOT OK");
        $finish;
    end

endmodule

### files.f
src/ccrn_pkg.sv
src/ccrn_store.sv
src/ccrn_engine.sv
src/cross_channel_response_norm_top.sv
src/ccrn_checker.sv
test/cross_channel_response_norm_checker.sv
test/cross_channel_response_norm_top_tb.sv
